### rtl/core/pgif_pkg.sv
`timescale 1ns / 1ps

package pgif_pkg;

    localparam int WIN_SIDE   = 3;
    localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
    localparam int CENTRE     = WIN_N / 2;
    localparam int PIX_W      = 24;
    localparam int DIST_W     = 13;
    localparam int SUM_W      = 17;
    localparam int SQ_W       = 18;
    localparam int RAD_W      = 2 * DIST_W;
    localparam int REM_W      = DIST_W + 3;
    localparam int ROOT_STEPS = DIST_W;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 4;
    localparam int THR_W      = 13;

    localparam logic [THR_W-1:0] THR_RESET = 13'd720;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam dist_t DIST_MAX = '1;

    typedef struct packed {
        pix_t win_p0;
        pix_t win_p1;
        pix_t win_p2;
        pix_t win_p3;
        pix_t win_p4;
        pix_t win_p5;
        pix_t win_p6;
        pix_t win_p7;
        pix_t win_p8;
    } in_word_t;

    typedef struct packed {
        pix_t filtered_pixel;
        logic replaced;
    } out_word_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic step;
        logic acc;
        logic centre;
    } lane_ctl_t;

    typedef struct packed {
        logic step;
        logic first;
    } merge_ctl_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROOT  = 6'b000100,
        ST_ACC   = 6'b001000,
        ST_MERGE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

### rtl/core/peer_group_impulse_filter_top.sv
`timescale 1ns / 1ps

// Peer-group impulse filter for one 3x3 RGB window per word. Nine lanes each own one window
// pixel and, in nine passes, measure its Q9.4 colour distance to every window pixel with a
// bit-serial square root of 13 steps, summing the distances and keeping the one to the
// centre. A merging stage then sweeps the lanes, one per cycle, to find the three smallest
// centre distances and the pixel with the least distance sum. No new word is accepted while
// one is in progress; the next word is accepted once the result is placed in the output
// register, which waits while a previous result is still held there.
module peer_group_impulse_filter_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pgif_pkg::in_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pgif_pkg::out_word_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [pgif_pkg::THR_W-1:0]   cfg_wr_data
);

    pgif_pkg::state_t               state_reg, state_next;
    logic [pgif_pkg::IDX_W-1:0]     j_reg, j_next;
    logic [pgif_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [pgif_pkg::THR_W-1:0]     thr_reg;
    pgif_pkg::pix_t                 win_reg [pgif_pkg::WIN_N];
    logic                           m_valid_reg, m_valid_next;
    pgif_pkg::out_word_t            m_data_reg, m_data_next;
    pgif_pkg::lane_ctl_t            lane_ctl;
    pgif_pkg::merge_ctl_t           merge_ctl;
    pgif_pkg::sum_t                 lane_sum [pgif_pkg::WIN_N];
    pgif_pkg::dist_t                lane_cdist [pgif_pkg::WIN_N];
    logic                           impulse;
    logic [pgif_pkg::IDX_W-1:0]     best_idx;
    logic                           accept;

    assign s_ready = (state_reg == pgif_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        lane_ctl     = '0;
        merge_ctl    = '0;
        unique case (state_reg)
            pgif_pkg::ST_IDLE: begin
                if (s_valid) begin
                    lane_ctl.clr = 1'b1;
                    j_next       = '0;
                    state_next   = pgif_pkg::ST_LOAD;
                end
            end
            pgif_pkg::ST_LOAD: begin
                lane_ctl.load = 1'b1;
                cnt_next      = '0;
                state_next    = pgif_pkg::ST_ROOT;
            end
            pgif_pkg::ST_ROOT: begin
                lane_ctl.step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == pgif_pkg::CNT_W'(pgif_pkg::ROOT_STEPS - 1)) begin
                    state_next = pgif_pkg::ST_ACC;
                end
            end
            pgif_pkg::ST_ACC: begin
                lane_ctl.acc    = 1'b1;
                lane_ctl.centre = (j_reg == pgif_pkg::IDX_W'(pgif_pkg::CENTRE));
                if (j_reg == pgif_pkg::IDX_W'(pgif_pkg::WIN_N - 1)) begin
                    j_next     = '0;
                    state_next = pgif_pkg::ST_MERGE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = pgif_pkg::ST_LOAD;
                end
            end
            pgif_pkg::ST_MERGE: begin
                merge_ctl.step  = 1'b1;
                merge_ctl.first = (j_reg == '0);
                if (j_reg == pgif_pkg::IDX_W'(pgif_pkg::WIN_N - 1)) begin
                    state_next = pgif_pkg::ST_DONE;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            pgif_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.replaced       = impulse;
                    m_data_next.filtered_pixel = impulse ? win_reg[best_idx]
                                                         : win_reg[pgif_pkg::CENTRE];
                    state_next                 = pgif_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pgif_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pgif_pkg::ST_IDLE;
            j_reg       <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= pgif_pkg::THR_RESET;
        end else begin
            state_reg   <= state_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            win_reg[0] <= s_data.win_p0;
            win_reg[1] <= s_data.win_p1;
            win_reg[2] <= s_data.win_p2;
            win_reg[3] <= s_data.win_p3;
            win_reg[4] <= s_data.win_p4;
            win_reg[5] <= s_data.win_p5;
            win_reg[6] <= s_data.win_p6;
            win_reg[7] <= s_data.win_p7;
            win_reg[8] <= s_data.win_p8;
        end
    end

    for (genvar g = 0; g < pgif_pkg::WIN_N; g++) begin : g_lane
        pgif_lane u_lane (
            .aclk        (aclk),
            .ctl         (lane_ctl),
            .own_pix     (win_reg[g]),
            .ref_pix     (win_reg[j_reg]),
            .pix_sum     (lane_sum[g]),
            .centre_dist (lane_cdist[g])
        );
    end

    pgif_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (merge_ctl),
        .lane_idx  (j_reg),
        .lane_dist (lane_cdist[j_reg]),
        .lane_sum  (lane_sum[j_reg]),
        .threshold (thr_reg),
        .impulse   (impulse),
        .best_idx  (best_idx)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new word taken while a window is in progress");
    a_centre_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && !m_data_reg.replaced) |->
        (m_data_reg.filtered_pixel == win_reg[pgif_pkg::CENTRE]))
        else $error("kept pixel is not the window centre");
    a_root_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pgif_pkg::ST_ROOT) |->
        (cnt_reg < pgif_pkg::CNT_W'(pgif_pkg::ROOT_STEPS)))
        else $error("square root ran past its step count");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        j_reg < pgif_pkg::IDX_W'(pgif_pkg::WIN_N))
        else $error("lane index out of range");
`endif

endmodule

### rtl/core/pgif_lane.sv
`timescale 1ns / 1ps

module pgif_lane (
    input  logic                 aclk,
    input  pgif_pkg::lane_ctl_t  ctl,
    input  pgif_pkg::pix_t       own_pix,
    input  pgif_pkg::pix_t       ref_pix,
    output pgif_pkg::sum_t       pix_sum,
    output pgif_pkg::dist_t      centre_dist
);

    logic [7:0]                     dr, dg, db;
    logic [15:0]                    sr, sg, sb;
    logic [pgif_pkg::SQ_W-1:0]      sq;
    logic [pgif_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [pgif_pkg::REM_W-1:0]     rem_reg, rem_next, rem_sh, trial;
    pgif_pkg::dist_t                root_reg, root_next;
    pgif_pkg::sum_t                 sum_reg, sum_next;
    pgif_pkg::dist_t                cdist_reg, cdist_next;

    always_comb begin
        dr = (own_pix[23:16] > ref_pix[23:16]) ? own_pix[23:16] - ref_pix[23:16]
                                               : ref_pix[23:16] - own_pix[23:16];
        dg = (own_pix[15:8] > ref_pix[15:8]) ? own_pix[15:8] - ref_pix[15:8]
                                             : ref_pix[15:8] - own_pix[15:8];
        db = (own_pix[7:0] > ref_pix[7:0]) ? own_pix[7:0] - ref_pix[7:0]
                                           : ref_pix[7:0] - own_pix[7:0];
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        sq = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};

        rem_sh = {rem_reg[pgif_pkg::REM_W-3:0], rad_reg[pgif_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};

        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        sum_next   = sum_reg;
        cdist_next = cdist_reg;

        if (ctl.load) begin
            rad_next  = {sq, 8'd0};
            rem_next  = '0;
            root_next = '0;
        end else if (ctl.step) begin
            rad_next = {rad_reg[pgif_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[pgif_pkg::DIST_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[pgif_pkg::DIST_W-2:0], 1'b0};
            end
        end
        if (ctl.clr) begin
            sum_next = '0;
        end else if (ctl.acc) begin
            sum_next = sum_reg + {{(pgif_pkg::SUM_W-pgif_pkg::DIST_W){1'b0}}, root_reg};
            if (ctl.centre) begin
                cdist_next = root_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        sum_reg   <= sum_next;
        cdist_reg <= cdist_next;
    end

    assign pix_sum     = sum_reg;
    assign centre_dist = cdist_reg;

endmodule

### rtl/core/pgif_merge.sv
`timescale 1ns / 1ps

module pgif_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pgif_pkg::merge_ctl_t         ctl,
    input  logic [pgif_pkg::IDX_W-1:0]   lane_idx,
    input  pgif_pkg::dist_t              lane_dist,
    input  pgif_pkg::sum_t               lane_sum,
    input  logic [pgif_pkg::THR_W-1:0]   threshold,
    output logic                         impulse,
    output logic [pgif_pkg::IDX_W-1:0]   best_idx
);

    pgif_pkg::dist_t               m0_reg, m0_next, m1_reg, m1_next, m2_reg, m2_next;
    pgif_pkg::sum_t                best_sum_reg, best_sum_next;
    logic [pgif_pkg::IDX_W-1:0]    best_idx_reg, best_idx_next;

    always_comb begin
        m0_next       = m0_reg;
        m1_next       = m1_reg;
        m2_next       = m2_reg;
        best_sum_next = best_sum_reg;
        best_idx_next = best_idx_reg;
        if (ctl.step) begin
            if (ctl.first) begin
                m0_next       = lane_dist;
                m1_next       = pgif_pkg::DIST_MAX;
                m2_next       = pgif_pkg::DIST_MAX;
                best_sum_next = lane_sum;
                best_idx_next = lane_idx;
            end else begin
                priority if (lane_dist < m0_reg) begin
                    m0_next = lane_dist;
                    m1_next = m0_reg;
                    m2_next = m1_reg;
                end else if (lane_dist < m1_reg) begin
                    m1_next = lane_dist;
                    m2_next = m1_reg;
                end else if (lane_dist < m2_reg) begin
                    m2_next = lane_dist;
                end else begin
                    m2_next = m2_reg;
                end
                if (lane_sum < best_sum_reg) begin
                    best_sum_next = lane_sum;
                    best_idx_next = lane_idx;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m0_reg       <= pgif_pkg::DIST_MAX;
            m1_reg       <= pgif_pkg::DIST_MAX;
            m2_reg       <= pgif_pkg::DIST_MAX;
            best_sum_reg <= '0;
            best_idx_reg <= '0;
        end else begin
            m0_reg       <= m0_next;
            m1_reg       <= m1_next;
            m2_reg       <= m2_next;
            best_sum_reg <= best_sum_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign impulse  = ((m1_reg - m0_reg) > threshold) || ((m2_reg - m1_reg) > threshold);
    assign best_idx = best_idx_reg;

`ifndef ASSERT_OFF
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m0_reg <= m1_reg) && (m1_reg <= m2_reg))
        else $error("smallest distances out of order");
`endif

endmodule
